>>> rtl/tlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and codes for the timestamp LRU associative cache.
// ----------------------------------------------------------------------------
package tlc_pkg;

  // operation codes
  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // configuration
  localparam int          CAP_W     = 7;
  localparam logic [6:0]  CAP_RESET = 7'd64;

  // fixed field widths
  localparam int KEY_W  = 64;
  localparam int HDL_W  = 32;
  localparam int STMP_W = 32;
  localparam int SLOT_W = 6;

  // input item
  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [HDL_W-1:0]  handle;
    logic [STMP_W-1:0] now;
  } tlc_in_t;

  // result item
  typedef struct packed {
    logic              hit;
    logic [HDL_W-1:0]  out_handle;
    logic              evicted;
    logic [SLOT_W-1:0] slot;
  } tlc_out_t;

  // entry store write enables
  typedef struct packed {
    logic key_hdl;
    logic stamp;
  } tlc_wr_t;

endpackage

>>> rtl/timestamp_lru_assoc_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_lru_assoc_cache
// Fully associative key-to-handle cache with least-recently-used
// replacement by time stamp.
// ----------------------------------------------------------------------------
// One item at a time. The entries sit in a single-port-read memory that is
// scanned one entry per cycle through one shared comparator, so the item
// time follows the number of filled entries F: a lookup that hits entry i
// ends its scan there, a lookup miss scans all F entries (none with nothing
// filled), an insert into a free entry needs no scan, and an insert that
// evicts scans all F entries for the oldest stamp.
// in_stall stays high from acceptance until the result is loaded into the
// output register; the result may then wait there while the next item is
// taken. The stores need no clearing after reset: only filled entries are
// ever read.
// ----------------------------------------------------------------------------
module timestamp_lru_assoc_cache #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tlc_pkg::tlc_in_t             in_data,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output tlc_pkg::tlc_out_t            out_data,
  // configuration
  input  logic                         cfg_we,
  input  logic [tlc_pkg::CAP_W-1:0]    cfg_wdata
);
  import tlc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;
  tlc_in_t           req_r, req_nxt;
  logic              hit_r, hit_nxt;
  logic              evict_r, evict_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [STMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic [HDL_W-1:0]  best_hdl_r, best_hdl_nxt;
  logic              out_vld_r, out_vld_nxt;
  tlc_out_t          out_r, out_nxt;

  logic [CMP_W-1:0]    eff_cap;
  logic                in_acc;
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [HDL_W-1:0]    rd_hdl;
  logic [STMP_W-1:0]   rd_stamp;
  tlc_wr_t             wr_en;
  logic                key_match;
  logic                stamp_better;
  logic                last_entry;

  // entry store
  tlc_entry_mem #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (best_idx_r),
    .wr_key   (req_r.key[KEY_BITS-1:0]),
    .wr_hdl   (req_r.handle),
    .wr_stamp (req_r.now),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_hdl   (rd_hdl),
    .rd_stamp (rd_stamp)
  );

  // capacity clamped to 1..ENTRIES
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_r) > ENTRIES_C) begin
      eff_cap = ENTRIES_C;
    end else begin
      eff_cap = CMP_W'(cap_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // shared compare unit: key equality and stamp ordering on the read entry
  assign key_match    = (rd_key == req_r.key[KEY_BITS-1:0]);
  assign stamp_better = (pend_idx_r == '0) || (rd_stamp < best_stamp_r);
  assign last_entry   = ((CNT_W'(pend_idx_r) + 1'b1) == fill_r);

  // read issue during the scan
  assign rd_en   = (state_r == S_SCAN) && (issue_r < fill_r);
  assign rd_addr = issue_r[IDX_W-1:0];

  // write-back
  assign wr_en.key_hdl = (state_r == S_WRITE) && (req_r.func == FUNC_INSERT);
  assign wr_en.stamp   = (state_r == S_WRITE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    issue_nxt      = issue_r;
    pend_vld_nxt   = rd_en;
    pend_idx_nxt   = rd_addr;
    req_nxt        = req_r;
    hit_nxt        = hit_r;
    evict_nxt      = evict_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    best_hdl_nxt   = best_hdl_r;
    out_vld_nxt    = out_vld_r && out_stall;
    out_nxt        = out_r;

    if (rd_en) begin
      issue_nxt = issue_r + 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt      = in_data;
          issue_nxt    = '0;
          pend_vld_nxt = 1'b0;
          hit_nxt      = 1'b0;
          evict_nxt    = 1'b0;
          best_idx_nxt = '0;
          best_hdl_nxt = '0;
          if (in_data.func == FUNC_LOOKUP) begin
            state_nxt = (fill_r == '0) ? S_DONE : S_SCAN;
          end else if (CMP_W'(fill_r) < eff_cap) begin
            best_idx_nxt = fill_r[IDX_W-1:0];
            fill_nxt     = fill_r + 1'b1;
            state_nxt    = S_WRITE;
          end else begin
            evict_nxt = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_vld_r) begin
          if (req_r.func == FUNC_LOOKUP) begin
            if (key_match) begin
              hit_nxt      = 1'b1;
              best_idx_nxt = pend_idx_r;
              best_hdl_nxt = rd_hdl;
              state_nxt    = S_WRITE;
            end else if (last_entry) begin
              state_nxt = S_DONE;
            end
          end else begin
            if (stamp_better) begin
              best_idx_nxt   = pend_idx_r;
              best_stamp_nxt = rd_stamp;
              best_hdl_nxt   = rd_hdl;
            end
            if (last_entry) begin
              state_nxt = S_WRITE;
            end
          end
        end
      end
      S_WRITE: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_r || !out_stall) begin
          out_vld_nxt        = 1'b1;
          out_nxt.hit        = hit_r;
          out_nxt.out_handle = best_hdl_r;
          out_nxt.evicted    = evict_r;
          out_nxt.slot       = SLOT_W'(best_idx_r);
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fill_r     <= '0;
      cap_r      <= CAP_RESET;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    issue_r      <= issue_nxt;
    pend_idx_r   <= pend_idx_nxt;
    req_r        <= req_nxt;
    hit_r        <= hit_nxt;
    evict_r      <= evict_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_hdl_r   <= best_hdl_nxt;
    out_r        <= out_nxt;
  end

`ifndef SYNTHESIS
  // fill never runs past the built depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= ENTRIES_C)
    else $error("fill count above depth");

  // fill only ever grows by one
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(fill_r) |-> (fill_r == $past(fill_r) + 1'b1))
    else $error("fill count jumped");

  // a result is never both a hit and an eviction
  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_r.hit && out_r.evicted))
    else $error("hit and evicted together");

  // the scan never reads beyond the filled entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (CNT_W'(rd_addr) < fill_r))
    else $error("scan read past fill");
`endif

endmodule

>>> rtl/tlc_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlc_entry_mem
// Entry store: key, handle and stamp arrays with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module tlc_entry_mem #(
  parameter int ENTRIES  = 64,
  parameter int KEY_BITS = 64,
  parameter int IDX_W    = 6
) (
  input  logic                       clk,
  input  tlc_pkg::tlc_wr_t           wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic [KEY_BITS-1:0]        wr_key,
  input  logic [tlc_pkg::HDL_W-1:0]  wr_hdl,
  input  logic [tlc_pkg::STMP_W-1:0] wr_stamp,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic [KEY_BITS-1:0]        rd_key,
  output logic [tlc_pkg::HDL_W-1:0]  rd_hdl,
  output logic [tlc_pkg::STMP_W-1:0] rd_stamp
);
  import tlc_pkg::*;

  logic [KEY_BITS-1:0] key_mem   [ENTRIES];
  logic [HDL_W-1:0]    hdl_mem   [ENTRIES];
  logic [STMP_W-1:0]   stamp_mem [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en.key_hdl) begin
      key_mem[wr_addr] <= wr_key;
      hdl_mem[wr_addr] <= wr_hdl;
    end
    if (wr_en.stamp) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_hdl   <= hdl_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timestamp LRU associative cache.
// ----------------------------------------------------------------------------
// A driver feeds lookup and insert items from a queue. On every accepted
// item a behavioural model of the cache predicts the result, and the monitor
// compares each accepted result, field by field, with the oldest prediction.
// The capacity register is rewritten between phases while the cache is idle
// (zero, over-range, lowered below the fill level). Each side of the cache
// idles at random, with the amount shifted from phase to phase.
// ----------------------------------------------------------------------------
module tb;
  import tlc_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int DRAIN_CYC   = 100;
  localparam int CYCLE_LIMIT = 1000000;

  // clock, reset and block ports
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  tlc_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  tlc_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata = '0;

  // model state
  logic [KEY_W-1:0]  key_mem   [ENTRIES];
  logic [HDL_W-1:0]  hdl_mem   [ENTRIES];
  logic [STMP_W-1:0] stamp_mem [ENTRIES];
  int unsigned       fill_cnt;
  logic [CAP_W-1:0]  cap_reg;

  // stimulus and expected replies
  tlc_in_t           op_q [$];
  tlc_out_t          reply_q [$];
  bit                in_fired   = 1'b0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  logic [STMP_W-1:0] stamp_clk  = '0;

  // bookkeeping
  int n_queued   = 0;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_errs     = 0;
  int n_lookups  = 0;
  int n_inserts  = 0;
  int n_hits     = 0;
  int n_evicts   = 0;
  int cycles     = 0;

  timestamp_lru_assoc_cache uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cache model: one access, updates the model state, returns the reply
  function automatic tlc_out_t cache_access(input tlc_in_t op);
    tlc_out_t    r;
    int unsigned lim;
    int unsigned victim;
    logic [STMP_W-1:0] oldest;
    r = '0;
    lim = (cap_reg == 0) ? 1 : ((cap_reg > ENTRIES) ? ENTRIES : cap_reg);
    if (op.func == FUNC_LOOKUP) begin
      // first matching key in index order wins
      for (int i = 0; i < fill_cnt; i++) begin
        if (!r.hit && key_mem[i] == op.key) begin
          r.hit        = 1'b1;
          r.out_handle = hdl_mem[i];
          r.slot       = SLOT_W'(i);
          stamp_mem[i] = op.now;
        end
      end
    end else begin
      if (fill_cnt < lim) begin
        victim = fill_cnt;
        fill_cnt++;
      end else begin
        // oldest stamp, lowest index on ties
        victim = 0;
        oldest = stamp_mem[0];
        for (int i = 1; i < fill_cnt; i++) begin
          if (stamp_mem[i] < oldest) begin
            oldest = stamp_mem[i];
            victim = i;
          end
        end
        r.evicted    = 1'b1;
        r.out_handle = hdl_mem[victim];
      end
      key_mem[victim]   = op.key;
      hdl_mem[victim]   = op.handle;
      stamp_mem[victim] = op.now;
      r.slot            = SLOT_W'(victim);
    end
    return r;
  endfunction

  // driver: next item at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fired) begin
      if (op_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= op_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // monitor: config mirror, result check, prediction on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt = 0;
      cap_reg  = CAP_RESET;
      in_fired = 1'b0;
    end else begin
      if (cfg_we)
        cap_reg = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          n_errs++;
          if (n_errs <= 10)
            $display("[%0t] unexpected result: hit=%0b handle=%h evicted=%0b slot=%0d",
                     $realtime, out_data.hit, out_data.out_handle,
                     out_data.evicted, out_data.slot);
        end else begin
          tlc_out_t exp_r;
          exp_r = reply_q.pop_front();
          n_checked++;
          if (exp_r.hit) n_hits++;
          if (exp_r.evicted) n_evicts++;
          if (out_data.hit !== exp_r.hit || out_data.out_handle !== exp_r.out_handle ||
              out_data.evicted !== exp_r.evicted || out_data.slot !== exp_r.slot) begin
            n_errs++;
            if (n_errs <= 10)
              $display("[%0t] mismatch #%0d: exp hit=%0b handle=%h evicted=%0b slot=%0d, got hit=%0b handle=%h evicted=%0b slot=%0d",
                       $realtime, n_checked, exp_r.hit, exp_r.out_handle,
                       exp_r.evicted, exp_r.slot, out_data.hit,
                       out_data.out_handle, out_data.evicted, out_data.slot);
          end
        end
      end
      in_fired = in_valid && !in_stall;
      if (in_fired) begin
        if (in_data.func == FUNC_LOOKUP) n_lookups++;
        else n_inserts++;
        reply_q.push_back(cache_access(in_data));
        n_accepted++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, n_accepted - n_checked);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic queue_op(input logic f, input logic [KEY_W-1:0] k,
                          input logic [HDL_W-1:0] h, input logic [STMP_W-1:0] t);
    tlc_in_t op;
    op.func   = f;
    op.key    = k;
    op.handle = h;
    op.now    = t;
    op_q.push_back(op);
    n_queued++;
  endtask

  // wait for every item to be answered, let the block settle
  task automatic wait_idle();
    while (!(n_accepted == n_queued && n_checked == n_accepted))
      @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random mix over a key pool of pool_n keys
  task automatic run_mix(input int n, input int pool_n);
    logic [KEY_W-1:0]  pool [$];
    logic [KEY_W-1:0]  k;
    logic [STMP_W-1:0] t;
    logic              f;
    int unsigned       pick;
    for (int i = 0; i < pool_n; i++)
      pool.push_back({$urandom, $urandom});
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      f = (pick < 50) ? FUNC_LOOKUP : FUNC_INSERT;
      k = (pick % 10 == 3) ? {$urandom, $urandom} : pool[$urandom_range(pool_n - 1)];
      // mostly a slowly rising clock with ties; some wild stamps
      case ($urandom_range(19))
        0: t = $urandom;
        1: t = $urandom_range(1) ? '1 : '0;
        default: begin
          stamp_clk = stamp_clk + $urandom_range(3);
          t = stamp_clk;
        end
      endcase
      queue_op(f, k, $urandom, t);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // capacity zero acts as one: empty miss, fill, evict
    set_capacity(7'd0);
    queue_op(FUNC_LOOKUP, '0, '1, 32'd3);
    queue_op(FUNC_INSERT, '0, '1, '0);
    queue_op(FUNC_INSERT, '1, '0, '1);
    queue_op(FUNC_LOOKUP, '1, 32'h1234_5678, 32'd7);
    queue_op(FUNC_LOOKUP, '0, '0, 32'd8);
    queue_op(FUNC_INSERT, 64'h5A5A_A5A5_0F0F_F0F0, 32'hA5A5_5A5A, 32'd9);

    // capacity three: duplicate keys, equal stamps, hit refreshes stamp
    set_capacity(7'd3);
    queue_op(FUNC_INSERT, '0, 32'h0000_000A, 32'd10);
    queue_op(FUNC_INSERT, '0, 32'h0000_000B, 32'd10);
    queue_op(FUNC_LOOKUP, '0, '1, 32'd20);
    queue_op(FUNC_INSERT, 64'd5, 32'h0000_000C, 32'd30);
    queue_op(FUNC_INSERT, 64'd6, 32'h0000_000D, 32'd30);
    queue_op(FUNC_INSERT, 64'd7, 32'h0000_000E, 32'd30);
    queue_op(FUNC_INSERT, 64'd8, 32'h0000_000F, 32'd30);
    queue_op(FUNC_LOOKUP, 64'd6, '0, '1);
    queue_op(FUNC_LOOKUP, 64'd5, '0, 32'd31);
    queue_op(FUNC_INSERT, 64'h8000_0000_0000_0001, 32'h8000_0001, 32'd32);

    // over-range capacity acts as the full depth
    set_capacity(7'd127);
    queue_op(FUNC_INSERT, 64'hFFFF_FFFF_0000_0000, '1, 32'd40);
    queue_op(FUNC_INSERT, 64'h0000_0000_FFFF_FFFF, '0, 32'd41);
    queue_op(FUNC_LOOKUP, 64'hFFFF_FFFF_0000_0000, '0, 32'd42);
    queue_op(FUNC_LOOKUP, 64'h0000_0000_FFFF_FFFF, '1, 32'd43);
    queue_op(FUNC_LOOKUP, 64'h1234_5678_9ABC_DEF0, '0, 32'd44);

    stamp_clk = 32'd100;

    // phase one: receiver busy
    set_capacity(7'd16);
    tx_idle_pct = 18;
    rx_idle_pct = 66;
    run_mix(250, 24);
    set_capacity(7'd5);  // below the fill level
    run_mix(150, 22);

    // phase two: sender sparse
    set_capacity(7'd40);
    tx_idle_pct = 66;
    rx_idle_pct = 18;
    run_mix(300, 52);
    set_capacity(7'd127);
    run_mix(350, 80);

    // phase three: full rate both sides
    set_capacity(7'd64);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_mix(450, 80);
    set_capacity(7'd1);
    run_mix(300, 80);

    wait_idle();
    n_errs += reply_q.size();
    $display("Covered %0d lookups (%0d hits) and %0d inserts (%0d evictions)",
             n_lookups, n_hits, n_inserts, n_evicts);
    $display("Capacity taken through 0, 1, 3, 5, 16, 40, 64 and 127; %0d errors",
             n_errs);
    if (n_errs == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
